### src/bcd_pkg.sv
// Types and constants shared by the command deframer.
package bcd_pkg;

  localparam logic [7:0] STUFF_MARK      = 8'hFA;
  localparam logic [7:0] SYNC_BYTE0      = 8'h00;
  localparam int         HDR_POS_SYNC0   = 0;
  localparam int         HDR_POS_SYNC1   = 1;
  localparam int         HDR_POS_SYNC2   = 2;
  localparam int         HDR_POS_SERIAL  = 3;
  localparam int         HDR_POS_LENGTH  = 4;
  localparam int         HDR_POS_COMMAND = 5;
  localparam int         HDR_FIRST_PAYLOAD = 6;
  localparam int         CONT_FIRST_PAYLOAD = 1;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       first_of_packet;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       frame_last;
    logic [7:0] serial_number;
    logic [7:0] command_code;
    logic [7:0] payload_count;
  } out_beat_t;

endpackage

### src/ble_command_deframer.sv
// Command frame deframer: header check, payload destuffing and frame end marking.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one decrypted
//   radio packet byte per beat; first_of_packet marks byte 0 of each packet.
//   Output channel (out_valid_o / out_stall_i / out_data_o) gives at most one
//   beat per input beat: a destuffed payload byte, or a bare end marker
//   (byte_valid low) when a frame closes without a kept byte.
//   A result is registered and appears in the cycle after its input beat.
//   Throughput: one input beat per cycle while in_stall_o is low; the state
//   update and result are computed in a single pass from the input and the
//   frame state registers into the output register.
//   Stall: while the output register holds an untaken beat and out_stall_i is
//   high, in_stall_o is high; otherwise a new byte is taken every cycle, also
//   while the current result is being taken.
//   Reset: asynchronous, active low; the block waits for a header packet and
//   the output register is empty.
//   Frame end: the block frees itself and ignores the rest of that packet.
module ble_command_deframer #(
  parameter int RADIO_PACKET_BYTES = 20,
  parameter int HEADER_PAYLOAD_MAX = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bcd_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bcd_pkg::out_beat_t  out_data_o
);

  localparam int PosW = $clog2(RADIO_PACKET_BYTES + 1);
  localparam int CmpW = 8;
  localparam logic [PosW-1:0] PosMax = PosW'(RADIO_PACKET_BYTES);
  localparam logic [CmpW-1:0] HdrLo  = CmpW'(bcd_pkg::HDR_FIRST_PAYLOAD);
  localparam logic [CmpW-1:0] HdrHi  =
    CmpW'(bcd_pkg::HDR_FIRST_PAYLOAD + HEADER_PAYLOAD_MAX);
  localparam logic [CmpW-1:0] ContLo = CmpW'(bcd_pkg::CONT_FIRST_PAYLOAD);

  logic [PosW-1:0] byte_pos_q, byte_pos_d;
  logic            in_frame_q, in_frame_d;
  logic            drop_q, drop_d;
  logic            hdr_pkt_q, hdr_pkt_d;
  logic            skip_q, skip_d;
  logic [7:0]      len_q, len_d;
  logic [7:0]      raw_q, raw_d;
  logic [7:0]      serial_q, serial_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [7:0]      kept_q, kept_d;

  logic               out_valid_q;
  bcd_pkg::out_beat_t out_q;

  logic               in_accept;
  logic               emit;
  logic               last;
  logic               keep;
  logic               take;
  logic [PosW-1:0]    pos;
  logic [CmpW-1:0]    pos_w;
  logic               drop_cur;
  logic               hdr_cur;
  logic [7:0]         b;
  bcd_pkg::out_beat_t res;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    b        = in_data_i.packet_byte;
    pos      = in_data_i.first_of_packet ? '0 : byte_pos_q;
    drop_cur = in_data_i.first_of_packet ? 1'b0 : drop_q;
    hdr_cur  = in_data_i.first_of_packet ? 1'b0 : hdr_pkt_q;
    pos_w    = CmpW'(pos);

    byte_pos_d = (pos < PosMax) ? pos + PosW'(1) : PosMax;
    in_frame_d = in_frame_q;
    drop_d     = drop_cur;
    hdr_pkt_d  = hdr_cur;
    skip_d     = skip_q;
    len_d      = len_q;
    raw_d      = raw_q;
    serial_d   = serial_q;
    cmd_d      = cmd_q;
    kept_d     = kept_q;

    emit = 1'b0;
    last = 1'b0;
    keep = 1'b0;
    take = 1'b0;
    res.payload_byte = '0;
    res.byte_valid   = 1'b0;

    if (pos < PosMax && !drop_cur) begin
      if (!in_frame_q) begin
        priority if (pos_w == CmpW'(bcd_pkg::HDR_POS_SYNC0)) begin
          if (b != bcd_pkg::SYNC_BYTE0) drop_d = 1'b1;
        end else if (pos_w == CmpW'(bcd_pkg::HDR_POS_SYNC1) ||
                     pos_w == CmpW'(bcd_pkg::HDR_POS_SYNC2)) begin
          if (b != bcd_pkg::STUFF_MARK) drop_d = 1'b1;
        end else if (pos_w == CmpW'(bcd_pkg::HDR_POS_SERIAL)) begin
          serial_d = b;
        end else if (pos_w == CmpW'(bcd_pkg::HDR_POS_LENGTH)) begin
          len_d = b;
        end else if (pos_w == CmpW'(bcd_pkg::HDR_POS_COMMAND)) begin
          cmd_d      = b;
          in_frame_d = 1'b1;
          hdr_pkt_d  = 1'b1;
          raw_d      = '0;
          kept_d     = '0;
          skip_d     = 1'b0;
          if (len_q == '0) begin
            emit       = 1'b1;
            last       = 1'b1;
            in_frame_d = 1'b0;
            hdr_pkt_d  = 1'b0;
            drop_d     = 1'b1;
          end
        end else begin
          drop_d = drop_cur;
        end
      end else begin
        take = hdr_cur ? (pos_w >= HdrLo && pos_w < HdrHi) : (pos_w >= ContLo);
        if (take && raw_q < len_q) begin
          raw_d = raw_q + 8'd1;
          if (skip_q) begin
            skip_d = 1'b0;
          end else begin
            keep   = 1'b1;
            kept_d = kept_q + 8'd1;
            skip_d = (b == bcd_pkg::STUFF_MARK);
          end
          last = (raw_d >= len_q);
          emit = keep | last;
          if (keep) begin
            res.payload_byte = b;
            res.byte_valid   = 1'b1;
          end
          if (last) begin
            in_frame_d = 1'b0;
            hdr_pkt_d  = 1'b0;
            drop_d     = 1'b1;
          end
        end
      end
    end

    res.frame_last    = last;
    res.serial_number = serial_d;
    res.command_code  = cmd_d;
    res.payload_count = kept_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q <= '0;
      in_frame_q <= 1'b0;
      drop_q     <= 1'b0;
      hdr_pkt_q  <= 1'b0;
      skip_q     <= 1'b0;
      len_q      <= '0;
      raw_q      <= '0;
      serial_q   <= '0;
      cmd_q      <= '0;
      kept_q     <= '0;
    end else if (in_accept) begin
      byte_pos_q <= byte_pos_d;
      in_frame_q <= in_frame_d;
      drop_q     <= drop_d;
      hdr_pkt_q  <= hdr_pkt_d;
      skip_q     <= skip_d;
      len_q      <= len_d;
      raw_q      <= raw_d;
      serial_q   <= serial_d;
      cmd_q      <= cmd_d;
      kept_q     <= kept_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_accept & emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && emit) begin
      out_q <= res;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  a_raw_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_frame_q |-> raw_q <= len_q)
    else $error("raw count passed frame length");

  a_bare_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.byte_valid)
      |-> (out_data_o.frame_last && out_data_o.payload_byte == 8'd0))
    else $error("bare marker without frame end or with data");

  a_frame_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && emit && last) |=> (!in_frame_q && drop_q))
    else $error("frame not freed after its last beat");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && emit) |=> out_valid_o)
    else $error("result lost");
`endif

endmodule
